### rtl/core/mcstb_pkg.sv
// ----------------------------------------------------------------------------
// mcstb_pkg
// Shared types, codes and constants for the multi-channel soft timer bank.
// ----------------------------------------------------------------------------
package mcstb_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	// Item modes
	localparam logic [3:0] MODE_FEED   = 4'd0;
	localparam logic [3:0] MODE_CREATE = 4'd1;
	localparam logic [3:0] MODE_REMOVE = 4'd2;
	localparam logic [3:0] MODE_IVAL   = 4'd3;
	localparam logic [3:0] MODE_PRIO   = 4'd4;
	localparam logic [3:0] MODE_PAUSE  = 4'd5;
	localparam logic [3:0] MODE_START  = 4'd6;
	localparam logic [3:0] MODE_STOP   = 4'd7;
	localparam logic [3:0] MODE_RESET  = 4'd8;
	localparam logic [3:0] MODE_FIRE   = 4'd9;
	localparam logic [3:0] MODE_TOP    = 4'd10;
	localparam logic [3:0] MODE_FIRST  = 4'd11;
	localparam logic [3:0] MODE_QUERY  = 4'd12;
	localparam logic [3:0] MODE_CLEAR  = 4'd13;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_HIT     = 2'd1;
	localparam logic [1:0] ST_NONE    = 2'd2;
	localparam logic [1:0] ST_NOALLOC = 2'd3;

	// Register indexes
	localparam logic REG_DIVIDER = 1'b0;
	localparam logic REG_WRAP    = 1'b1;

	typedef struct packed {
		logic [3:0]  mode;
		logic [3:0]  slot;
		logic [31:0] raw_ticks;
		logic [7:0]  overflow_count;
		logic [31:0] amount;
		logic [15:0] prio_in;
		logic        pause_flag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  found_slot;
		logic [31:0] count_out;
		logic        paused_out;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;
		logic fstart;
		logic ftime;
		logic sdiv_start;
		logic swrite;
		logic skip;
		logic idx_inc;
		logic scan;
		logic take_wr;
		logic clr_slot;
		logic clr_rem;
		logic exec;
		logic load_out;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [3:0] mode;
		logic       div_on;
		logic       div_busy;
		logic       t_zero;
		logic       idx_last;
		logic       slot_active;
	} stat_t;

endpackage

### rtl/core/mcstb_div.sv
// ----------------------------------------------------------------------------
// mcstb_div
// Restoring divider, 33-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module mcstb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [32:0] quot,
	output logic [31:0] rem
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] r_q;
	logic [32:0] q_q;
	logic [31:0] d_q;
	logic [32:0] rn;
	logic        ge;

	// one trial subtraction per cycle
	assign rn = {r_q, q_q[32]};
	assign ge = rn >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd32)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? 32'(rn - {1'b0, d_q}) : rn[31:0];
			q_q <= {q_q[31:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

### rtl/core/mcstb_dp.sv
// ----------------------------------------------------------------------------
// mcstb_dp
// Timer bank datapath: slot stores, feed time, shared divider, result regs.
// ----------------------------------------------------------------------------
module mcstb_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mcstb_pkg::cmd_t     cmd,
	output mcstb_pkg::stat_t    stat,
	input  mcstb_pkg::in_item_t in_item,
	output mcstb_pkg::out_item_t out_item,
	input  logic [15:0]         tick_divider,
	input  logic [31:0]         wrap_period
);

	localparam int SW = mcstb_pkg::SLOT_W;
	localparam int N  = mcstb_pkg::SLOTS;

	mcstb_pkg::in_item_t  item_q;
	mcstb_pkg::out_item_t res_q;
	mcstb_pkg::out_item_t out_q;

	logic [31:0] iv_q [N];
	logic [31:0] el_q [N];
	logic [31:0] pd_q [N];
	logic [15:0] pr_q [N];
	logic [N-1:0] pa_q;
	logic [N-1:0] al_q;
	logic [15:0] rem_q;

	logic [39:0] prod_q;
	logic [31:0] t_q;
	logic [SW-1:0] idx_q;
	logic        any_q;
	logic        have_q;
	logic [SW-1:0] best_q;
	logic [15:0] best_prio_q;
	logic [31:0] best_cnt_q;

	logic [SW-1:0] rd_idx;
	logic [31:0] iv_rd, el_rd, pd_rd;
	logic [15:0] pr_rd;
	logic        al_rd, pa_rd;
	logic        div_on;
	logic        dv_start, dv_busy;
	logic [32:0] dv_dvd, dv_q;
	logic [31:0] dv_dvs, dv_r;
	logic [31:0] t_base;
	logic [40:0] t_sum;
	logic [33:0] p_sum;
	logic [31:0] p_new;
	logic [32:0] f_sum;
	logic        need_alloc;
	logic        cand;

	// single read port into the slot stores
	assign rd_idx = cmd.exec ? item_q.slot[SW-1:0] : idx_q;
	assign iv_rd  = iv_q[rd_idx];
	assign el_rd  = el_q[rd_idx];
	assign pd_rd  = pd_q[rd_idx];
	assign pr_rd  = pr_q[rd_idx];
	assign al_rd  = al_q[rd_idx];
	assign pa_rd  = pa_q[rd_idx];

	assign div_on = tick_divider > 16'd1;

	// divider shared by the tick scaling and the per-slot interval division
	assign dv_start = cmd.fstart | cmd.sdiv_start;
	assign dv_dvd   = cmd.fstart ? ({1'b0, item_q.raw_ticks} + {17'b0, rem_q})
	                             : ({1'b0, el_rd} + {1'b0, t_q});
	assign dv_dvs   = cmd.fstart ? {16'b0, tick_divider} : iv_rd;

	mcstb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_dvd),
		.divisor  (dv_dvs),
		.busy     (dv_busy),
		.quot     (dv_q),
		.rem      (dv_r)
	);

	// feed time, saturated
	assign t_base = div_on ? dv_q[31:0] : item_q.raw_ticks;
	assign t_sum  = {9'b0, t_base} + {1'b0, prod_q};

	// pending plus whole intervals, saturated
	assign p_sum = {2'b0, pd_rd} + {1'b0, dv_q};
	assign p_new = (p_sum[33:32] != 2'b00) ? '1 : p_sum[31:0];

	// pending plus fired amount, saturated
	assign f_sum = {1'b0, pd_rd} + {1'b0, item_q.amount};

	assign need_alloc = ((item_q.mode >= mcstb_pkg::MODE_REMOVE) &&
	                     (item_q.mode <= mcstb_pkg::MODE_FIRE)) ||
	                    (item_q.mode == mcstb_pkg::MODE_QUERY);

	assign cand = al_rd && (pd_rd != 32'd0);

	// sweep and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			any_q  <= 1'b0;
			have_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				idx_q  <= '0;
				any_q  <= 1'b0;
				have_q <= 1'b0;
			end
			if (cmd.idx_inc)
				idx_q <= idx_q + SW'(1);
			if (cmd.swrite && (p_new != 32'd0))
				any_q <= 1'b1;
			if (cmd.skip && cand)
				any_q <= 1'b1;
			if (cmd.scan && cand && (!have_q ||
			    ((item_q.mode == mcstb_pkg::MODE_TOP) && (pr_rd > best_prio_q))))
				have_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_item;
			prod_q <= {32'b0, in_item.overflow_count} * {8'b0, wrap_period};
		end
		if (cmd.ftime)
			t_q <= (t_sum[40:32] != 9'd0) ? '1 : t_sum[31:0];
		if (cmd.scan && cand && (!have_q ||
		    ((item_q.mode == mcstb_pkg::MODE_TOP) && (pr_rd > best_prio_q)))) begin
			best_q      <= idx_q;
			best_prio_q <= pr_rd;
			best_cnt_q  <= pd_rd;
		end
	end

	// result of the item in hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			out_q <= '0;
		end else begin
			if (cmd.latch)
				res_q <= '0;
			if (cmd.exec) begin
				if (need_alloc && !al_rd)
					res_q.status <= mcstb_pkg::ST_NOALLOC;
				else if (item_q.mode == mcstb_pkg::MODE_QUERY) begin
					res_q.count_out  <= pd_rd;
					res_q.paused_out <= pa_rd;
				end
			end
			if (cmd.take_wr) begin
				if (have_q) begin
					res_q.status     <= mcstb_pkg::ST_HIT;
					res_q.found_slot <= 4'(best_q);
					res_q.count_out  <= best_cnt_q;
				end else
					res_q.status <= mcstb_pkg::ST_NONE;
			end
			if (cmd.load_out) begin
				if (item_q.mode == mcstb_pkg::MODE_FEED) begin
					out_q        <= '0;
					out_q.status <= any_q ? mcstb_pkg::ST_HIT : mcstb_pkg::ST_OK;
				end else
					out_q <= res_q;
			end
		end
	end

	// slot stores and carried remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				iv_q[i] <= '0;
				el_q[i] <= '0;
				pd_q[i] <= '0;
				pr_q[i] <= '0;
			end
			pa_q  <= '0;
			al_q  <= '0;
			rem_q <= '0;
		end else begin
			if (cmd.ftime && div_on)
				rem_q <= dv_r[15:0];
			if (cmd.clr_rem)
				rem_q <= '0;
			if (cmd.swrite) begin
				pd_q[rd_idx] <= p_new;
				el_q[rd_idx] <= dv_r;
			end
			if (cmd.clr_slot && al_rd) begin
				el_q[rd_idx] <= '0;
				pd_q[rd_idx] <= '0;
			end
			if (cmd.take_wr && have_q)
				pd_q[best_q] <= '0;
			if (cmd.exec && !(need_alloc && !al_rd)) begin
				case (item_q.mode)
					mcstb_pkg::MODE_CREATE: begin
						al_q[rd_idx] <= 1'b1;
						iv_q[rd_idx] <= item_q.amount;
						pr_q[rd_idx] <= item_q.prio_in;
						el_q[rd_idx] <= '0;
						pd_q[rd_idx] <= '0;
						pa_q[rd_idx] <= 1'b0;
					end
					mcstb_pkg::MODE_REMOVE: begin
						al_q[rd_idx] <= 1'b0;
						iv_q[rd_idx] <= '0;
						pr_q[rd_idx] <= '0;
						el_q[rd_idx] <= '0;
						pd_q[rd_idx] <= '0;
						pa_q[rd_idx] <= 1'b0;
					end
					mcstb_pkg::MODE_IVAL:  iv_q[rd_idx] <= item_q.amount;
					mcstb_pkg::MODE_PRIO:  pr_q[rd_idx] <= item_q.prio_in;
					mcstb_pkg::MODE_PAUSE: pa_q[rd_idx] <= item_q.pause_flag;
					mcstb_pkg::MODE_START, mcstb_pkg::MODE_STOP: begin
						el_q[rd_idx] <= '0;
						pd_q[rd_idx] <= '0;
						pa_q[rd_idx] <= (item_q.mode == mcstb_pkg::MODE_STOP);
					end
					mcstb_pkg::MODE_RESET: begin
						el_q[rd_idx] <= '0;
						pd_q[rd_idx] <= '0;
					end
					mcstb_pkg::MODE_FIRE:
						pd_q[rd_idx] <= f_sum[32] ? '1 : f_sum[31:0];
					default: ;
				endcase
			end
		end
	end

	// status towards the controller
	assign stat.mode        = item_q.mode;
	assign stat.div_on      = div_on;
	assign stat.div_busy    = dv_busy;
	assign stat.t_zero      = (t_q == 32'd0);
	assign stat.idx_last    = (idx_q == SW'(N - 1));
	assign stat.slot_active = al_rd && !pa_rd && (iv_rd != 32'd0);

	assign out_item = out_q;

endmodule

### rtl/core/mcstb_ctrl.sv
// ----------------------------------------------------------------------------
// mcstb_ctrl
// Sequencer for the timer bank: dispatch, feed sweep, take scan, clear sweep.
// ----------------------------------------------------------------------------
module mcstb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  mcstb_pkg::stat_t stat,
	output mcstb_pkg::cmd_t  cmd
);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_DISP   = 13'b0000000000010,
		S_EXEC   = 13'b0000000000100,
		S_FSTART = 13'b0000000001000,
		S_FWAIT  = 13'b0000000010000,
		S_FTIME  = 13'b0000000100000,
		S_FCHK   = 13'b0000001000000,
		S_SREAD  = 13'b0000010000000,
		S_SWAIT  = 13'b0000100000000,
		S_SCAN   = 13'b0001000000000,
		S_TAKE   = 13'b0010000000000,
		S_CLEAR  = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.mode)
					mcstb_pkg::MODE_FEED:
						state_d = stat.div_on ? S_FSTART : S_FTIME;
					mcstb_pkg::MODE_TOP, mcstb_pkg::MODE_FIRST:
						state_d = S_SCAN;
					mcstb_pkg::MODE_CLEAR:
						state_d = S_CLEAR;
					default:
						state_d = S_EXEC;
				endcase
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_DONE;
			end
			S_FSTART: begin
				cmd.fstart = 1'b1;
				state_d    = S_FWAIT;
			end
			S_FWAIT: begin
				if (!stat.div_busy)
					state_d = S_FTIME;
			end
			S_FTIME: begin
				cmd.ftime = 1'b1;
				state_d   = S_FCHK;
			end
			S_FCHK: begin
				state_d = stat.t_zero ? S_DONE : S_SREAD;
			end
			S_SREAD: begin
				if (stat.slot_active) begin
					cmd.sdiv_start = 1'b1;
					state_d        = S_SWAIT;
				end else begin
					cmd.skip = 1'b1;
					if (stat.idx_last)
						state_d = S_DONE;
					else
						cmd.idx_inc = 1'b1;
				end
			end
			S_SWAIT: begin
				if (!stat.div_busy) begin
					cmd.swrite = 1'b1;
					if (stat.idx_last)
						state_d = S_DONE;
					else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_SREAD;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.idx_last)
					state_d = S_TAKE;
				else
					cmd.idx_inc = 1'b1;
			end
			S_TAKE: begin
				cmd.take_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_CLEAR: begin
				cmd.clr_slot = 1'b1;
				if (stat.idx_last) begin
					cmd.clr_rem = 1'b1;
					state_d     = S_DONE;
				end else
					cmd.idx_inc = 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/multi_channel_soft_timer_bank.sv
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank
// Bank of sixteen periodic timers addressed by slot, with an APB register port.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall, in_item) carry one command: a feed of raw
// counter ticks and overflows, a slot operation, a take or a clear-all.
// Every input beat yields exactly one output beat (out_valid/out_stall,
// out_item), in order.
// Slot operations pass through the dispatch and execute states to the output
// register; clear-all sweeps the slots and a take scans them all. A feed
// first scales the ticks on the shared radix-2 divider when tick_divider
// exceeds 1, then reads each slot in turn and runs a divider pass for every
// running slot, stepping over idle slots.
// One command is in progress at a time; the next input beat is taken as soon
// as the previous result has moved into the output register, which holds it
// while the receiver stalls. A stalled output delays only the end of the
// following command.
// Reset clears all slots, the carried remainder and sets tick_divider to 1
// and wrap_period to 65535. Registers: tick_divider at 0x0, wrap_period at
// 0x4; write them only while the bank is idle.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  mcstb_pkg::in_item_t   in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output mcstb_pkg::out_item_t  out_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [15:0] div_q;
	logic [31:0] wrap_q;
	logic        wr_en;

	mcstb_pkg::cmd_t  cmd;
	mcstb_pkg::stat_t stat;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= 16'd1;
			wrap_q <= 32'd65535;
		end else if (wr_en) begin
			if (paddr[2] == mcstb_pkg::REG_DIVIDER)
				div_q <= pwdata[15:0];
			else
				wrap_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == mcstb_pkg::REG_WRAP) ? wrap_q : {16'b0, div_q};

	mcstb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mcstb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_item      (in_item),
		.out_item     (out_item),
		.tick_divider (div_q),
		.wrap_period  (wrap_q)
	);

endmodule

### tb/sv/multi_channel_soft_timer_bank_tb.sv
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank_tb
// Self-checking bench for the soft timer bank: a queue-fed driver offers
// command beats with random gaps, a monitor takes result beats under random
// stall, and a behavioural model of the bank predicts every result.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank_tb;

	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	mcstb_pkg::in_item_t  in_item;
	logic                 out_valid;
	logic                 out_stall;
	mcstb_pkg::out_item_t out_item;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	multi_channel_soft_timer_bank u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Model state of the bank
	logic [31:0] m_ival [mcstb_pkg::SLOTS];
	logic [31:0] m_elap [mcstb_pkg::SLOTS];
	logic [31:0] m_pend [mcstb_pkg::SLOTS];
	logic [15:0] m_prio [mcstb_pkg::SLOTS];
	logic        m_paused [mcstb_pkg::SLOTS];
	logic        m_alloc [mcstb_pkg::SLOTS];
	logic [31:0] m_rem;
	logic [15:0] m_div;
	logic [31:0] m_wrap;

	mcstb_pkg::in_item_t  cmd_q [$];
	mcstb_pkg::out_item_t result_q [$];
	int        n_err;
	int        n_beats_out;
	int        n_hits;
	bit        hold_req;
	bit        hold_off;
	bit        stim_done;
	bit        burst;
	logic      in_stall_q;

	// Clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {33'd0, a} + {1'b0, b};
		return (s > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Predict the result of one command and update the model
	function automatic mcstb_pkg::out_item_t timer_predict(mcstb_pkg::in_item_t c);
		mcstb_pkg::out_item_t r;
		logic [63:0] t, tot;
		int best;
		bit have;
		bit al;
		int s;
		r = '0;
		s = c.slot;
		al = m_alloc[s];
		if (((c.mode >= mcstb_pkg::MODE_REMOVE && c.mode <= mcstb_pkg::MODE_FIRE) ||
		     c.mode == mcstb_pkg::MODE_QUERY) && !al)
			r.status = mcstb_pkg::ST_NOALLOC;
		else begin
			case (c.mode)
				mcstb_pkg::MODE_FEED: begin
					t = {32'd0, c.raw_ticks};
					if (m_div > 16'd1) begin
						t = t + m_rem;
						m_rem = 32'(t % m_div);
						t = t / m_div;
					end
					t = t + 64'(c.overflow_count) * 64'(m_wrap);
					if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
					if (t != 0) begin
						for (int i = 0; i < mcstb_pkg::SLOTS; i++) begin
							if (!m_alloc[i]) continue;
							if (!m_paused[i] && m_ival[i] != 0) begin
								tot = 64'(m_elap[i]) + t;
								m_pend[i] = sat_sum(m_pend[i], tot / m_ival[i]);
								m_elap[i] = 32'(tot % m_ival[i]);
							end
							if (m_pend[i] != 0) r.status = mcstb_pkg::ST_HIT;
						end
					end
				end
				mcstb_pkg::MODE_CREATE: begin
					m_alloc[s] = 1'b1; m_ival[s] = c.amount; m_prio[s] = c.prio_in;
					m_elap[s] = '0; m_pend[s] = '0; m_paused[s] = 1'b0;
				end
				mcstb_pkg::MODE_REMOVE: begin
					m_alloc[s] = 1'b0; m_ival[s] = '0; m_prio[s] = '0;
					m_elap[s] = '0; m_pend[s] = '0; m_paused[s] = 1'b0;
				end
				mcstb_pkg::MODE_IVAL:  m_ival[s] = c.amount;
				mcstb_pkg::MODE_PRIO:  m_prio[s] = c.prio_in;
				mcstb_pkg::MODE_PAUSE: m_paused[s] = c.pause_flag;
				mcstb_pkg::MODE_START, mcstb_pkg::MODE_STOP: begin
					m_elap[s] = '0; m_pend[s] = '0;
					m_paused[s] = (c.mode == mcstb_pkg::MODE_STOP);
				end
				mcstb_pkg::MODE_RESET: begin
					m_elap[s] = '0; m_pend[s] = '0;
				end
				mcstb_pkg::MODE_FIRE: m_pend[s] = sat_sum(m_pend[s], 64'(c.amount));
				mcstb_pkg::MODE_TOP, mcstb_pkg::MODE_FIRST: begin
					have = 0;
					best = 0;
					for (int i = 0; i < mcstb_pkg::SLOTS; i++) begin
						if (!m_alloc[i] || m_pend[i] == 0) continue;
						if (!have || (c.mode == mcstb_pkg::MODE_TOP &&
						    m_prio[i] > m_prio[best])) begin
							best = i;
							if (c.mode == mcstb_pkg::MODE_FIRST && !have) begin
								have = 1;
								break;
							end
							have = 1;
						end
					end
					if (have) begin
						r.status = mcstb_pkg::ST_HIT;
						r.found_slot = 4'(best);
						r.count_out = m_pend[best];
						m_pend[best] = '0;
					end else
						r.status = mcstb_pkg::ST_NONE;
				end
				mcstb_pkg::MODE_QUERY: begin
					r.count_out = m_pend[s];
					r.paused_out = m_paused[s];
				end
				mcstb_pkg::MODE_CLEAR: begin
					for (int i = 0; i < mcstb_pkg::SLOTS; i++) begin
						if (m_alloc[i]) begin
							m_elap[i] = '0; m_pend[i] = '0;
						end
					end
					m_rem = '0;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	// Stall as seen at the last rising edge decides whether the beat went
	always @(posedge clk) in_stall_q <= in_stall;

	// Driver: offers queued commands with random gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else if (!in_valid || !in_stall_q) begin
			if (cmd_q.size() != 0 && ($urandom_range(0, 3) != 0 || burst)) begin
				in_item  <= cmd_q[0];
				result_q.push_back(timer_predict(cmd_q.pop_front()));
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// Long receiver hold-off, counted here once requested
	initial begin
		hold_off = 0;
		wait (hold_req);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	// Receiver back-pressure
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (hold_off)
			out_stall <= 1'b1;
		else if (burst)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 4) == 0);
	end

	// Monitor: compare every result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_beats_out++;
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, out_item);
				n_err++;
			end else begin
				mcstb_pkg::out_item_t e;
				e = result_q.pop_front();
				if (e.status == mcstb_pkg::ST_HIT) n_hits++;
				if (e.status != out_item.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, out_item.status);
					n_err++;
				end
				if (e.found_slot != out_item.found_slot) begin
					$display("%0t: found_slot exp %0d got %0d", $time, e.found_slot,
						out_item.found_slot);
					n_err++;
				end
				if (e.count_out != out_item.count_out) begin
					$display("%0t: count_out exp %h got %h", $time, e.count_out,
						out_item.count_out);
					n_err++;
				end
				if (e.paused_out != out_item.paused_out) begin
					$display("%0t: paused_out exp %0d got %0d", $time, e.paused_out,
						out_item.paused_out);
					n_err++;
				end
			end
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == mcstb_pkg::REG_DIVIDER) m_div = v[15:0];
		else m_wrap = v;
	endtask

	// Wait for every result, then let the bank settle
	task automatic drain();
		while (cmd_q.size() != 0 || result_q.size() != 0 || in_valid) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic mcstb_pkg::in_item_t rand_cmd(bit wellformed);
		mcstb_pkg::in_item_t c;
		c = mcstb_pkg::in_item_t'(97'({$urandom, $urandom, $urandom, $urandom}));
		c.slot = (wellformed && $urandom_range(0, 1)) ? 4'($urandom_range(0, 5)) : c.slot;
		if (wellformed) begin
			case ($urandom_range(0, 9))
				0, 1, 2: c.mode = mcstb_pkg::MODE_FEED;
				3: c.mode = mcstb_pkg::MODE_CREATE;
				default: c.mode = 4'($urandom_range(2, 13));
			endcase
			if ($urandom_range(0, 3) != 0) c.amount = $urandom_range(0, 300);
			if ($urandom_range(0, 3) != 0) c.raw_ticks = $urandom_range(0, 5000);
			if ($urandom_range(0, 2) != 0) c.overflow_count = 8'($urandom_range(0, 1));
			if ($urandom_range(0, 1)) c.prio_in = 16'($urandom_range(0, 3));
		end
		return c;
	endfunction

	function automatic mcstb_pkg::in_item_t mk(logic [3:0] md, logic [3:0] sl,
			logic [31:0] amt, logic [15:0] pr, logic [31:0] raw, logic [7:0] ovf,
			logic pf);
		mcstb_pkg::in_item_t c;
		c.mode = md; c.slot = sl; c.amount = amt; c.prio_in = pr;
		c.raw_ticks = raw; c.overflow_count = ovf; c.pause_flag = pf;
		return c;
	endfunction

	// Stimulus
	initial begin
		logic [31:0] divs [4];
		logic [31:0] wraps [4];
		divs  = '{32'd1, 32'd65535, 32'd7, 32'd0};
		wraps = '{32'd1, 32'hFFFF_FFFF, 32'd100, 32'd65535};
		n_err = 0; n_beats_out = 0; n_hits = 0;
		hold_req = 0; stim_done = 0; burst = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		m_div = 16'd1; m_wrap = 32'd65535; m_rem = '0;
		for (int i = 0; i < mcstb_pkg::SLOTS; i++) begin
			m_ival[i] = '0; m_elap[i] = '0; m_pend[i] = '0; m_prio[i] = '0;
			m_paused[i] = 0; m_alloc[i] = 0;
		end
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every mode, extremes and corner cases
		cmd_q.push_back(mk(mcstb_pkg::MODE_QUERY, 4'd3, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_TOP, 4'd0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_CREATE, 4'd0, 32'd10, 16'd0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_CREATE, 4'd15, 32'd1, 16'hFFFF, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_CREATE, 4'd5, 32'd0, 16'd7, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_CREATE, 4'd6, 32'hFFFF_FFFF, 16'd7, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_FEED, 4'd0, 32'd0, 0, 32'd0, 8'd0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_FEED, 4'd0, 0, 0, 32'hFFFF_FFFF, 8'hFF, 1));
		cmd_q.push_back(mk(mcstb_pkg::MODE_FEED, 4'd0, 0, 0, 32'd25, 8'd0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_FIRE, 4'd15, 32'hFFFF_FFFF, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_FIRE, 4'd5, 32'd3, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_PRIO, 4'd5, 0, 16'hFFFF, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_TOP, 4'd0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_FIRST, 4'd0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_PAUSE, 4'd0, 0, 0, 0, 0, 1));
		cmd_q.push_back(mk(mcstb_pkg::MODE_QUERY, 4'd0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_IVAL, 4'd0, 32'd3, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_START, 4'd0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_STOP, 4'd6, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_RESET, 4'd15, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_REMOVE, 4'd6, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_IVAL, 4'd6, 32'd5, 0, 0, 0, 0));
		cmd_q.push_back(mk(mcstb_pkg::MODE_CLEAR, 4'd0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(4'd14, 4'd0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(4'd15, 4'd9, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1));
		drain();

		// Random phases across register settings; long hold-off in the first
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(mcstb_pkg::REG_DIVIDER, divs[ph]);
			reg_write(mcstb_pkg::REG_WRAP, wraps[ph]);
			for (int k = 0; k < 245; k++)
				cmd_q.push_back(rand_cmd($urandom_range(0, 9) != 0));
			if (ph == 0) hold_req = 1;
			if (ph == 2) burst = 1;
			drain();
			burst = 0;
		end
		stim_done = 1;
		$display("Ran %0d result beats over 4 divider/wrap settings, %0d hits or takes.",
			n_beats_out, n_hits);
		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
